[hw/rtl/i2cm_pkg.sv]
// Package for the I2C master byte engine: field widths, command and phase codes,
// and the structs passed between the engine's modules. No dependencies.
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int FUNC_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int TICKS_W    = 16;
  localparam int POLL_W     = 8;
  localparam int BITCNT_W   = 4;
  localparam int PHASE_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [TICKS_W-1:0] PHASE_TICKS_RST    = 16'd4;
  localparam logic [POLL_W-1:0]  ACK_POLL_LIMIT_RST = 8'd250;

  // Bits per byte, as a bit counter value.
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 2'd1;

  // Bus sequencer phases.
  localparam logic [PHASE_W-1:0] PH_IDLE    = 5'd0;
  localparam logic [PHASE_W-1:0] PH_ST_A    = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ST_B    = 5'd2;
  localparam logic [PHASE_W-1:0] PH_ST_C    = 5'd3;
  localparam logic [PHASE_W-1:0] PH_SP_A    = 5'd4;
  localparam logic [PHASE_W-1:0] PH_SP_B    = 5'd5;
  localparam logic [PHASE_W-1:0] PH_SP_C    = 5'd6;
  localparam logic [PHASE_W-1:0] PH_WR_LOW  = 5'd7;
  localparam logic [PHASE_W-1:0] PH_WR_DATA = 5'd8;
  localparam logic [PHASE_W-1:0] PH_WR_HIGH = 5'd9;
  localparam logic [PHASE_W-1:0] PH_WA_LOW  = 5'd10;
  localparam logic [PHASE_W-1:0] PH_WA_HIGH = 5'd11;
  localparam logic [PHASE_W-1:0] PH_WA_POLL = 5'd12;
  localparam logic [PHASE_W-1:0] PH_RD_LOW  = 5'd13;
  localparam logic [PHASE_W-1:0] PH_RD_HIGH = 5'd14;
  localparam logic [PHASE_W-1:0] PH_MA_LOW  = 5'd15;
  localparam logic [PHASE_W-1:0] PH_MA_HIGH = 5'd16;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] wr_data;
    logic              master_nack;
    logic              sda_in;
  } i2cm_item_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rd_byte;
    logic              ack_timeout;
  } i2cm_res_t;

  typedef struct packed {
    logic [TICKS_W-1:0] phase_ticks;
    logic [POLL_W-1:0]  ack_poll_limit;
  } i2cm_cfg_t;

endpackage

[hw/rtl/i2cm_ifs.sv]
// Channel interfaces of the I2C master byte engine: tick input, result output
// and configuration write. Depends on i2cm_pkg.
`timescale 1ns / 1ps
interface i2cm_in_if import i2cm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] wr_data;
  logic              master_nack;
  logic              sda_in;

  modport source (output valid, func, wr_data, master_nack, sda_in, input ready);
  modport sink   (input valid, func, wr_data, master_nack, sda_in, output ready);
endinterface

interface i2cm_out_if import i2cm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_level;
  logic              sda_drive;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rd_byte;
  logic              ack_timeout;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rd_byte, ack_timeout, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rd_byte, ack_timeout, output ready);
endinterface

interface i2cm_cfg_if import i2cm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/i2cm_cfg_regs.sv]
// Configuration registers of the I2C master byte engine (phase length and
// ack poll limit). Depends on i2cm_pkg and i2cm_cfg_if.
`timescale 1ns / 1ps
module i2cm_cfg_regs import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_cfg_if.sink   cfg_ch,
  output i2cm_cfg_t  cfg
);

  logic [TICKS_W-1:0] phase_ticks_r;
  logic [POLL_W-1:0]  ack_poll_limit_r;
  logic               wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r    <= PHASE_TICKS_RST;
      ack_poll_limit_r <= ACK_POLL_LIMIT_RST;
    end else if (wr_en) begin
      case (cfg_ch.index)
        CFG_PHASE_TICKS:    phase_ticks_r    <= cfg_ch.data[TICKS_W-1:0];
        CFG_ACK_POLL_LIMIT: ack_poll_limit_r <= cfg_ch.data[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.phase_ticks    = phase_ticks_r;
  assign cfg.ack_poll_limit = ack_poll_limit_r;

endmodule

[hw/rtl/i2cm_seq.sv]
// Bus phase sequencer of the I2C master byte engine: holds the bus state and
// advances it by one tick per step. Depends on i2cm_pkg.
`timescale 1ns / 1ps
module i2cm_seq import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  i2cm_item_t item,
  input  i2cm_cfg_t  cfg,
  output i2cm_res_t  res
);

  logic [PHASE_W-1:0]  phase_r,   phase_nxt;
  logic [BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [BYTE_W-1:0]   shift_r,   shift_nxt;
  logic [TICKS_W-1:0]  delay_r,   delay_nxt;
  logic [POLL_W-1:0]   poll_r,    poll_nxt;
  logic                scl_r,     scl_nxt;
  logic                sda_r,     sda_nxt;
  logic                oe_r,      oe_nxt;
  logic                nack_r,    nack_nxt;
  logic                tmo_r,     tmo_nxt;
  logic [BYTE_W-1:0]   rd_r,      rd_nxt;

  logic                done;
  logic                go;
  logic [PHASE_W-1:0]  tgt;
  logic [BITCNT_W-1:0] bit_inc;
  logic [BYTE_W-1:0]   shift_in;

  assign bit_inc  = bit_cnt_r + 1'b1;
  assign shift_in = {shift_r[BYTE_W-2:0], item.sda_in};

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    delay_nxt   = delay_r;
    poll_nxt    = poll_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    oe_nxt      = oe_r;
    nack_nxt    = nack_r;
    tmo_nxt     = tmo_r;
    rd_nxt      = rd_r;
    done        = 1'b0;
    go          = 1'b0;
    tgt         = PH_IDLE;

    if (phase_r == PH_IDLE) begin
      case (item.func)
        FUNC_START: begin
          bit_cnt_nxt = '0;
          go          = 1'b1;
          tgt         = PH_ST_A;
        end
        FUNC_STOP: begin
          bit_cnt_nxt = '0;
          go          = 1'b1;
          tgt         = PH_SP_A;
        end
        FUNC_WRITE: begin
          bit_cnt_nxt = '0;
          shift_nxt   = item.wr_data;
          go          = 1'b1;
          tgt         = PH_WR_LOW;
        end
        FUNC_READ: begin
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          nack_nxt    = item.master_nack;
          go          = 1'b1;
          tgt         = PH_RD_LOW;
        end
        default: ;
      endcase
    end else if (phase_r == PH_WA_POLL) begin
      // A low SDA is the slave's ack; otherwise poll until the limit is reached.
      if (!item.sda_in || poll_r >= cfg.ack_poll_limit) begin
        tmo_nxt   = item.sda_in;
        scl_nxt   = 1'b0;
        oe_nxt    = 1'b1;
        phase_nxt = PH_IDLE;
        delay_nxt = '0;
        done      = 1'b1;
      end else begin
        poll_nxt = poll_r + 1'b1;
      end
    end else if (delay_r < cfg.phase_ticks) begin
      delay_nxt = delay_r + 1'b1;
    end else begin
      case (phase_r)
        PH_ST_A:    begin go = 1'b1; tgt = PH_ST_B;    end
        PH_ST_B:    begin go = 1'b1; tgt = PH_ST_C;    end
        PH_SP_A:    begin go = 1'b1; tgt = PH_SP_B;    end
        PH_SP_B:    begin go = 1'b1; tgt = PH_SP_C;    end
        PH_WR_LOW:  begin go = 1'b1; tgt = PH_WR_DATA; end
        PH_WR_DATA: begin go = 1'b1; tgt = PH_WR_HIGH; end
        PH_WR_HIGH: begin
          bit_cnt_nxt = bit_inc;
          go          = 1'b1;
          tgt         = (bit_inc >= BITS_PER_BYTE) ? PH_WA_LOW : PH_WR_LOW;
        end
        PH_WA_LOW:  begin go = 1'b1; tgt = PH_WA_HIGH; end
        PH_WA_HIGH: begin go = 1'b1; tgt = PH_WA_POLL; end
        PH_RD_LOW:  begin go = 1'b1; tgt = PH_RD_HIGH; end
        PH_RD_HIGH: begin
          // SDA is sampled on the last tick of the SCL-high phase.
          shift_nxt   = shift_in;
          bit_cnt_nxt = bit_inc;
          go          = 1'b1;
          if (bit_inc >= BITS_PER_BYTE) begin
            rd_nxt = shift_in;
            tgt    = PH_MA_LOW;
          end else begin
            tgt    = PH_RD_LOW;
          end
        end
        PH_MA_LOW:  begin go = 1'b1; tgt = PH_MA_HIGH; end
        PH_MA_HIGH: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          delay_nxt = '0;
          done      = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
          delay_nxt = '0;
          done      = 1'b1;
        end
      endcase
    end

    // Entry actions of the phase being entered; the entry tick counts as the first.
    if (go) begin
      phase_nxt = tgt;
      delay_nxt = {{(TICKS_W-1){1'b0}}, 1'b1};
      case (tgt)
        PH_ST_A:    sda_nxt = 1'b1;
        PH_ST_B:    scl_nxt = 1'b1;
        PH_ST_C:    sda_nxt = 1'b0;
        PH_SP_A:    sda_nxt = 1'b0;
        PH_SP_B:    scl_nxt = 1'b1;
        PH_SP_C:    sda_nxt = 1'b1;
        PH_WR_LOW:  scl_nxt = 1'b0;
        PH_WR_DATA: begin
          sda_nxt   = shift_r[BYTE_W-1];
          shift_nxt = {shift_r[BYTE_W-2:0], 1'b0};
        end
        PH_WR_HIGH: scl_nxt = 1'b1;
        PH_WA_LOW:  scl_nxt = 1'b0;
        PH_WA_HIGH: begin
          scl_nxt = 1'b1;
          oe_nxt  = 1'b0;
        end
        PH_WA_POLL: poll_nxt = '0;
        PH_RD_LOW: begin
          scl_nxt = 1'b0;
          oe_nxt  = 1'b0;
        end
        PH_RD_HIGH: scl_nxt = 1'b1;
        PH_MA_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = nack_r;
          oe_nxt  = 1'b1;
        end
        PH_MA_HIGH: scl_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      delay_r   <= '0;
      poll_r    <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      oe_r      <= 1'b1;
      nack_r    <= 1'b0;
      tmo_r     <= 1'b0;
      rd_r      <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      delay_r   <= delay_nxt;
      poll_r    <= poll_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      oe_r      <= oe_nxt;
      nack_r    <= nack_nxt;
      tmo_r     <= tmo_nxt;
      rd_r      <= rd_nxt;
    end
  end

  assign res.scl_level   = scl_nxt;
  assign res.sda_level   = sda_nxt;
  assign res.sda_drive   = oe_nxt;
  assign res.busy_res    = (phase_nxt != PH_IDLE);
  assign res.done_res    = done;
  assign res.rd_byte     = rd_nxt;
  assign res.ack_timeout = tmo_nxt;

endmodule

[hw/rtl/i2c_master_byte_engine_core.sv]
// Top level of the I2C master byte engine: input register, bus sequencer and
// result register. Depends on i2cm_pkg, i2cm_ifs, i2cm_cfg_regs and i2cm_seq.
`timescale 1ns / 1ps
// Each transfer on in_ch is one tick of the I2C bus sequencer and yields exactly one
// result transfer on out_ch, in order. The engine takes one tick per clock cycle while
// out_ch is not stalled: a tick is held in the input register, and the sequencer
// advances the bus state in one combinational pass as the tick moves into the result
// register. in_ch.ready drops only while the result register is full and out_ch is
// stalled. Configuration writes on cfg_ch are always taken, and should
// be made only while no tick is in flight; a write to an unknown index is ignored.
module i2c_master_byte_engine_core import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch,
  i2cm_cfg_if.sink    cfg_ch
);

  i2cm_cfg_t  cfg;
  i2cm_item_t item_r;
  i2cm_res_t  res;
  i2cm_res_t  res_r;
  logic       item_vld_r;
  logic       out_vld_r;
  logic       adv;

  // The held tick moves on when the result register is empty or being drained.
  assign adv         = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        item_vld_r <= in_ch.valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.func        <= in_ch.func;
      item_r.wr_data     <= in_ch.wr_data;
      item_r.master_nack <= in_ch.master_nack;
      item_r.sda_in      <= in_ch.sda_in;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  i2cm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  i2cm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_ch.valid       = out_vld_r;
  assign out_ch.scl_level   = res_r.scl_level;
  assign out_ch.sda_level   = res_r.sda_level;
  assign out_ch.sda_drive   = res_r.sda_drive;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.done_res    = res_r.done_res;
  assign out_ch.rd_byte     = res_r.rd_byte;
  assign out_ch.ack_timeout = res_r.ack_timeout;

endmodule

[hw/rtl/i2cm_checker.sv]
// Port-level checks for the I2C master byte engine and the bind that attaches
// them to i2c_master_byte_engine_core. Depends on i2cm_pkg.
`timescale 1ns / 1ps
module i2cm_checker import i2cm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              scl_level,
  input logic              sda_level,
  input logic              sda_drive,
  input logic              busy_res,
  input logic              done_res,
  input logic [BYTE_W-1:0] rd_byte,
  input logic              ack_timeout
);

  logic              out_xfer;
  logic [BYTE_W-1:0] last_rd_r;
  logic              last_tmo_r;

  assign out_xfer = out_valid && out_ready;

  // Status seen in the last result transfer; reset matches the engine's reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rd_r  <= '0;
      last_tmo_r <= 1'b0;
    end else if (out_xfer) begin
      last_rd_r  <= rd_byte;
      last_tmo_r <= ack_timeout;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(scl_level) && $stable(sda_level)
      && $stable(sda_drive) && $stable(busy_res) && $stable(done_res))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // The read byte is captured after its last bit, while the ack phases still follow.
  a_rd_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !busy_res |-> rd_byte == last_rd_r)
    else $error("read byte changed outside a command");

  a_tmo_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !done_res |-> ack_timeout == last_tmo_r)
    else $error("ack timeout changed without a completed command");

endmodule

bind i2c_master_byte_engine_core i2cm_checker u_i2cm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .scl_level   (out_ch.scl_level),
  .sda_level   (out_ch.sda_level),
  .sda_drive   (out_ch.sda_drive),
  .busy_res    (out_ch.busy_res),
  .done_res    (out_ch.done_res),
  .rd_byte     (out_ch.rd_byte),
  .ack_timeout (out_ch.ack_timeout)
);
